>>> design/ortoc_pkg.sv
// shared types, codes and constants of the relay on/off controller
package ortoc_pkg;

    // number of relays held in the state memory (1 to 4)
    localparam int RELAY_COUNT = 4;
    localparam int RELAY_AW    = (RELAY_COUNT > 1) ? $clog2(RELAY_COUNT) : 1;

    localparam logic [15:0] TIME_LIMIT = 16'hFFFF;

    typedef enum logic [2:0] {
        MODE_ON           = 3'd0,
        MODE_OFF          = 3'd1,
        MODE_TOGGLE       = 3'd2,
        MODE_OFF_EFFECT   = 3'd3,
        MODE_RECALL_SCENE = 3'd4,
        MODE_ON_TIMED_OFF = 3'd5,
        MODE_TICK         = 3'd6
    } t_mode;

    localparam logic [1:0] BL_ON      = 2'd0;
    localparam logic [1:0] BL_OFF     = 2'd1;
    localparam logic [1:0] BL_FOLLOW  = 2'd2;
    localparam logic [1:0] BL_INVERSE = 2'd3;

    // one relay's entry in the state memory
    typedef struct packed {
        logic        relay_on;
        logic [15:0] on_ticks;
        logic [15:0] off_wait;
        logic        scene;
    } t_relay_rec;

    localparam t_relay_rec REC_RESET = '{
        relay_on: 1'b0, on_ticks: 16'd0, off_wait: 16'd0, scene: 1'b1
    };

    // command held for the update stage
    typedef struct packed {
        logic [2:0]  mode;
        logic [1:0]  relay;
        logic        only_on;
        logic [15:0] on_req;
        logic [15:0] off_req;
    } t_cmd;

    // outcome of one read-modify-write
    typedef struct packed {
        t_relay_rec rec;
        logic       inv;
        logic       running;
        logic [1:0] owner;
    } t_upd;

endpackage

>>> design/ortoc_ram.sv
// generic single-write, single-read memory with registered read data
module ortoc_ram #(
    parameter int WIDTH = 34,
    parameter int DEPTH = 4,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/ortoc_update.sv
// next-state logic for one relay entry and the shared countdown
module ortoc_update
    import ortoc_pkg::*;
(
    input  t_cmd       i_cmd,
    input  logic       i_rel_ok,
    input  t_relay_rec i_rec,
    input  logic       i_running,
    input  logic [1:0] i_owner,
    output t_upd       o_upd
);

    logic [15:0] w_on_dec;
    logic [15:0] w_off_dec;

    assign w_on_dec  = i_rec.on_ticks - 16'd1;
    assign w_off_dec = i_rec.off_wait - 16'd1;

    function automatic t_relay_rec drive(t_relay_rec rec, logic lvl);
        t_relay_rec res;
        res = rec;
        if (lvl) begin
            res.scene    = 1'b1;
            res.relay_on = 1'b1;
            if (rec.on_ticks == 16'd0) begin
                res.off_wait = 16'd0;
            end
        end else begin
            res.relay_on = 1'b0;
            res.on_ticks = 16'd0;
        end
        return res;
    endfunction

    always_comb begin
        t_relay_rec v_rec;
        v_rec         = i_rec;
        o_upd.rec     = i_rec;
        o_upd.inv     = 1'b0;
        o_upd.running = i_running;
        o_upd.owner   = i_owner;

        if (t_mode'(i_cmd.mode) == MODE_TICK) begin
            if (i_running) begin
                if (!i_rel_ok) begin
                    o_upd.running = 1'b0;
                end else begin
                    if (i_rec.relay_on && i_rec.on_ticks != 16'd0) begin
                        o_upd.rec.on_ticks = w_on_dec;
                        // on time expired: relay drops, off-wait cleared
                        if (w_on_dec == 16'd0) begin
                            o_upd.rec.off_wait = 16'd0;
                            o_upd.rec.relay_on = 1'b0;
                            o_upd.inv          = 1'b1;
                        end
                    end else if (!i_rec.relay_on && i_rec.off_wait != 16'd0) begin
                        o_upd.rec.off_wait = w_off_dec;
                    end
                    if (o_upd.rec.on_ticks == 16'd0 && o_upd.rec.off_wait == 16'd0) begin
                        o_upd.running = 1'b0;
                    end
                end
            end
        end else if (i_rel_ok) begin
            case (t_mode'(i_cmd.mode))
                MODE_ON: begin
                    o_upd.rec = drive(i_rec, 1'b1);
                    o_upd.inv = 1'b1;
                end
                MODE_OFF: begin
                    o_upd.rec = drive(i_rec, 1'b0);
                    o_upd.inv = 1'b1;
                end
                MODE_TOGGLE: begin
                    o_upd.rec = drive(i_rec, !i_rec.relay_on);
                    o_upd.inv = 1'b1;
                end
                MODE_OFF_EFFECT: begin
                    v_rec.scene = 1'b0;
                    o_upd.rec   = drive(v_rec, 1'b0);
                    o_upd.inv   = 1'b1;
                end
                MODE_RECALL_SCENE: begin
                    o_upd.rec.scene = 1'b1;
                end
                MODE_ON_TIMED_OFF: begin
                    if (!(i_cmd.only_on && !i_rec.relay_on)) begin
                        if (i_rec.off_wait != 16'd0 && !i_rec.relay_on) begin
                            // already waiting off: only shorten the wait
                            if (i_cmd.off_req < i_rec.off_wait) begin
                                v_rec.off_wait = i_cmd.off_req;
                            end
                        end else begin
                            if (i_cmd.on_req > i_rec.on_ticks) begin
                                v_rec.on_ticks = i_cmd.on_req;
                            end
                            v_rec.off_wait = i_cmd.off_req;
                            v_rec          = drive(v_rec, 1'b1);
                            o_upd.inv      = 1'b1;
                        end
                        o_upd.rec = v_rec;
                        if (v_rec.on_ticks != TIME_LIMIT && v_rec.off_wait != TIME_LIMIT &&
                            (v_rec.on_ticks != 16'd0 || v_rec.off_wait != 16'd0)) begin
                            o_upd.running = 1'b1;
                            o_upd.owner   = i_cmd.relay;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

>>> design/onoff_relay_timed_off_ctrl.sv
// top level of the relay on/off controller with timed-off countdown
// o_valid rises when the calc state loads the output register after the input transfer; calc waits for room there
// one item in work at a time, set by the read-then-write turn on the state memory
// a waiting result still lets one more input transfer in, after that the input closes
// reset (synchronous, active low): relays off, times zero, scene flags set,
// countdown stopped, backlight modes 0xaa; no clearing pass, per-entry valid bits
module onoff_relay_timed_off_ctrl
    import ortoc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_mode,
    input  logic [1:0]  i_relay,
    input  logic        i_accept_only_when_on,
    input  logic [15:0] i_on_time_request,
    input  logic [15:0] i_off_wait_request,
    // configuration
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_data,
    // result channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_relay_index,
    output logic        o_relay_on,
    output logic        o_backlight_lit,
    output logic [15:0] o_on_time,
    output logic [15:0] o_off_wait_time,
    output logic        o_global_scene_control,
    output logic        o_scene_invalidated,
    output logic        o_timer_active,
    output logic [1:0]  o_timer_relay
);

    typedef enum logic {
        S_IDLE,
        S_CALC
    } t_state;

    t_state r_state;

    // captured command; relay field already holds the reported relay
    t_cmd r_cmd;

    // shared countdown
    logic       r_running;
    logic [1:0] r_owner;

    // backlight mode register
    logic [7:0] r_backlight_modes;

    // per-entry valid bits: an entry never written reads as its reset value
    logic [RELAY_COUNT-1:0] r_entry_valid;

    // output register
    logic        r_o_valid;
    logic [1:0]  r_o_relay_index;
    logic        r_o_relay_on;
    logic        r_o_backlight_lit;
    logic [15:0] r_o_on_time;
    logic [15:0] r_o_off_wait_time;
    logic        r_o_scene_ctrl;
    logic        r_o_scene_inv;
    logic        r_o_timer_active;
    logic [1:0]  r_o_timer_relay;

    logic                         w_in_xfer;
    logic                         w_out_free;
    logic                         w_commit;
    logic [1:0]                   w_rel_in;
    logic [RELAY_AW-1:0]          w_rd_addr;
    logic [RELAY_AW-1:0]          w_wr_addr;
    logic                         w_rel_ok;
    logic [$bits(t_relay_rec)-1:0] w_rdata;
    t_relay_rec                   w_rec_cur;
    t_upd                         w_upd;
    logic [1:0]                   w_bm;
    logic                         w_backlight;

    assign o_ready    = (r_state == S_IDLE);
    assign w_in_xfer  = i_valid && o_ready;
    // output register free this cycle, or being drained
    assign w_out_free = !r_o_valid || i_ready;
    assign w_commit   = (r_state == S_CALC) && w_out_free;

    // a tick addresses the countdown owner
    assign w_rel_in  = (t_mode'(i_mode) == MODE_TICK) ? r_owner : i_relay;
    assign w_rd_addr = w_rel_in[RELAY_AW-1:0];
    assign w_wr_addr = r_cmd.relay[RELAY_AW-1:0];
    assign w_rel_ok  = {1'b0, r_cmd.relay} < 3'(RELAY_COUNT);

    // relay state memory: read on transfer, written back on commit
    ortoc_ram #(
        .WIDTH ($bits(t_relay_rec)),
        .DEPTH (RELAY_COUNT)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (w_commit && w_rel_ok),
        .i_waddr (w_wr_addr),
        .i_wdata (w_upd.rec),
        .i_re    (w_in_xfer),
        .i_raddr (w_rd_addr),
        .o_rdata (w_rdata)
    );

    assign w_rec_cur = r_entry_valid[w_wr_addr] ? t_relay_rec'(w_rdata) : REC_RESET;

    ortoc_update u_update (
        .i_cmd     (r_cmd),
        .i_rel_ok  (w_rel_ok),
        .i_rec     (w_rec_cur),
        .i_running (r_running),
        .i_owner   (r_owner),
        .o_upd     (w_upd)
    );

    // backlight level of the reported relay
    assign w_bm = r_backlight_modes[{r_cmd.relay, 1'b0} +: 2];

    always_comb begin
        case (w_bm)
            BL_ON:      w_backlight = 1'b1;
            BL_OFF:     w_backlight = 1'b0;
            BL_FOLLOW:  w_backlight = w_upd.rec.relay_on;
            BL_INVERSE: w_backlight = !w_upd.rec.relay_on;
            default:    w_backlight = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_backlight_modes <= 8'd170;
        end else if (i_cfg_we) begin
            r_backlight_modes <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_running     <= 1'b0;
            r_owner       <= 2'd0;
            r_entry_valid <= '0;
            r_o_valid     <= 1'b0;
        end else begin
            // output drained by the consumer
            if (r_o_valid && i_ready) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_xfer) begin
                        r_cmd.mode    <= i_mode;
                        r_cmd.relay   <= w_rel_in;
                        r_cmd.only_on <= i_accept_only_when_on;
                        r_cmd.on_req  <= i_on_time_request;
                        r_cmd.off_req <= i_off_wait_request;
                        r_state       <= S_CALC;
                    end
                end
                S_CALC: begin
                    // memory data is held until the output register has room
                    if (w_out_free) begin
                        if (w_rel_ok) begin
                            r_entry_valid[w_wr_addr] <= 1'b1;
                        end
                        r_running         <= w_upd.running;
                        r_owner           <= w_upd.owner;
                        r_o_valid         <= 1'b1;
                        r_o_relay_index   <= r_cmd.relay;
                        r_o_relay_on      <= w_rel_ok && w_upd.rec.relay_on;
                        r_o_backlight_lit <= w_rel_ok && w_backlight;
                        r_o_on_time       <= w_rel_ok ? w_upd.rec.on_ticks : 16'd0;
                        r_o_off_wait_time <= w_rel_ok ? w_upd.rec.off_wait : 16'd0;
                        r_o_scene_ctrl    <= w_rel_ok && w_upd.rec.scene;
                        r_o_scene_inv     <= w_rel_ok && w_upd.inv;
                        r_o_timer_active  <= w_upd.running;
                        r_o_timer_relay   <= w_upd.owner;
                        r_state           <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid                = r_o_valid;
    assign o_relay_index          = r_o_relay_index;
    assign o_relay_on             = r_o_relay_on;
    assign o_backlight_lit        = r_o_backlight_lit;
    assign o_on_time              = r_o_on_time;
    assign o_off_wait_time        = r_o_off_wait_time;
    assign o_global_scene_control = r_o_scene_ctrl;
    assign o_scene_invalidated    = r_o_scene_inv;
    assign o_timer_active         = r_o_timer_active;
    assign o_timer_relay          = r_o_timer_relay;

endmodule

>>> design/ortoc_checker.sv
// port-level checks of the relay controller, bound to the top level
module ortoc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [1:0]  o_relay_index,
    input logic        o_relay_on,
    input logic [15:0] o_on_time,
    input logic [15:0] o_off_wait_time,
    input logic [1:0]  o_timer_relay
);

    // reset leaves no result pending and the input open
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && o_ready)
        else $error("result pending or input closed after reset");

    // a stalled result holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_relay_index) &&
            $stable(o_on_time) && $stable(o_off_wait_time) && $stable(o_timer_relay))
        else $error("stalled result changed");

    // one item in work at a time
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("second transfer while an item is in work");

    // with a free output, a result follows the transfer once the calc state has loaded the output register
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && (!o_valid || i_ready) |=> ##1 o_valid)
        else $error("result missing two cycles after transfer");

    // a relay that is off has no on time left
    a_off_no_on_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_relay_on |-> o_on_time == 16'd0)
        else $error("relay off with on time remaining");

endmodule

bind onoff_relay_timed_off_ctrl ortoc_checker u_checker (.*);
